// File: rtl/hcs_pkg.sv
// Shared types, codes and hex digit helpers for the hex codec stream.
// No dependencies; every other file in rtl uses it by scoped names.
package hcs_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] MODE_ENC_LOWER = 2'd0;
   localparam logic [1:0] MODE_ENC_UPPER = 2'd1;
   localparam logic [1:0] MODE_DEC_STRICT = 2'd2;
   localparam logic [1:0] MODE_DEC_SPACE  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_SHORT   = 2'd2;

   typedef enum logic [1:0] {
      OP_ENCODE = 2'd0,
      OP_BYTE   = 2'd1,
      OP_FINAL  = 2'd2
   } op_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_item;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        has_byte;
      logic        final_res;
      logic [1:0]  status;
      logic [15:0] byte_count;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       upper;
      logic       last;
      logic [1:0] status;
   } cmd_type;

   // {invalid, value}
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b0, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'h0, nib};
      end else if (upper) begin
         r = 8'h37 + {4'h0, nib};
      end else begin
         r = 8'h57 + {4'h0, nib};
      end
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

endpackage

// File: rtl/hcs_front.sv
// Front end: takes input beats, tracks the half pair and sticky error,
// and issues commands to the queue. Depends on hcs_pkg.
module hcs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data,
   input  logic              push,
   input  hcs_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output hcs_pkg::cmd_type  q_cmd
);

   logic [1:0] mode_ff;
   logic       pend_valid_ff, pend_valid_in;
   logic [3:0] pend_nib_ff, pend_nib_in;
   logic [1:0] err_ff, err_in;
   logic       accept;
   logic       have;
   logic [7:0] val;
   logic [4:0] dv;
   logic       last;
   logic [7:0] c;

   assign accept = push && !q_full;
   assign c      = req_data.in_byte;
   assign last   = req_data.last_item;
   assign dv     = hcs_pkg::digit_value(c);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_nib_in   = pend_nib_ff;
      err_in        = err_ff;
      have          = 1'b0;
      val           = 8'h00;
      if (mode_ff == hcs_pkg::MODE_DEC_STRICT || mode_ff == hcs_pkg::MODE_DEC_SPACE) begin
         if (err_ff == hcs_pkg::ST_OK) begin
            if (!pend_valid_ff) begin
               if (mode_ff == hcs_pkg::MODE_DEC_SPACE && last) begin
                  err_in = hcs_pkg::ST_SHORT;
               end else if (mode_ff == hcs_pkg::MODE_DEC_SPACE && hcs_pkg::is_space(c)) begin
                  pend_valid_in = 1'b0;
               end else if (dv[4]) begin
                  err_in = hcs_pkg::ST_INVALID;
               end else begin
                  pend_valid_in = 1'b1;
                  pend_nib_in   = dv[3:0];
               end
            end else begin
               if (dv[4]) begin
                  err_in = hcs_pkg::ST_INVALID;
               end else begin
                  val           = {pend_nib_ff, dv[3:0]};
                  have          = 1'b1;
                  pend_valid_in = 1'b0;
                  pend_nib_in   = 4'h0;
               end
            end
            if (last && mode_ff == hcs_pkg::MODE_DEC_STRICT &&
                err_in == hcs_pkg::ST_OK && pend_valid_in) begin
               err_in = hcs_pkg::ST_SHORT;
            end
         end
      end
   end

   always_comb begin
      q_cmd.data   = c;
      q_cmd.upper  = (mode_ff == hcs_pkg::MODE_ENC_UPPER);
      q_cmd.last   = last;
      q_cmd.status = err_in;
      if (mode_ff == hcs_pkg::MODE_ENC_LOWER || mode_ff == hcs_pkg::MODE_ENC_UPPER) begin
         q_cmd.op = hcs_pkg::OP_ENCODE;
         q_push   = accept;
      end else if (have) begin
         q_cmd.op   = hcs_pkg::OP_BYTE;
         q_cmd.data = val;
         q_push     = accept;
      end else begin
         q_cmd.op   = hcs_pkg::OP_FINAL;
         q_cmd.data = 8'h00;
         q_push     = accept && last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= hcs_pkg::MODE_ENC_LOWER;
         pend_valid_ff <= 1'b0;
         pend_nib_ff   <= 4'h0;
         err_ff        <= hcs_pkg::ST_OK;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (accept) begin
            // clear run state at the end of a run
            if (last) begin
               pend_valid_ff <= 1'b0;
               pend_nib_ff   <= 4'h0;
               err_ff        <= hcs_pkg::ST_OK;
            end else begin
               pend_valid_ff <= pend_valid_in;
               pend_nib_ff   <= pend_nib_in;
               err_ff        <= err_in;
            end
         end
      end
   end

endmodule

// File: rtl/hcs_queue.sv
// Command queue between front and back ends, QUEUE_DEPTH entries.
// Depends on hcs_pkg.
module hcs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  hcs_pkg::cmd_type  wr_cmd,
   output logic              q_full,
   input  logic              rd_en,
   output hcs_pkg::cmd_type  rd_cmd,
   output logic              q_empty
);

   hcs_pkg::cmd_type                mem_ff [hcs_pkg::QUEUE_DEPTH];
   logic [hcs_pkg::QUEUE_AW-1:0]    wr_ptr_ff;
   logic [hcs_pkg::QUEUE_AW-1:0]    rd_ptr_ff;
   logic [hcs_pkg::QUEUE_AW:0]      fill_ff;
   logic                            do_wr;
   logic                            do_rd;

   assign q_full  = (fill_ff == (hcs_pkg::QUEUE_AW+1)'(hcs_pkg::QUEUE_DEPTH));
   assign q_empty = (fill_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_cmd  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/hcs_back.sv
// Back end: expands commands into result beats, keeps the output count
// and holds the result register. Depends on hcs_pkg.
module hcs_back #(
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  hcs_pkg::cmd_type  q_cmd,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output hcs_pkg::rsp_type  rsp_data
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic                  rsp_valid_ff, rsp_valid_in;
   hcs_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  take;
   logic                  fire;

   assign take      = !rsp_valid_ff || pop;
   assign fire      = take && !q_empty;
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign empty     = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rsp_valid_in = take ? fire : rsp_valid_ff;
      rsp_in       = rsp_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      q_pop        = 1'b0;
      if (fire) begin
         rsp_in.status = q_cmd.status;
         case (q_cmd.op)
            hcs_pkg::OP_ENCODE: begin
               rsp_in.has_byte   = 1'b1;
               rsp_in.byte_count = 16'(count_inc);
               if (!phase_ff) begin
                  rsp_in.out_byte  = hcs_pkg::digit_char(q_cmd.data[7:4], q_cmd.upper);
                  rsp_in.final_res = 1'b0;
                  count_in         = count_inc;
                  phase_in         = 1'b1;
               end else begin
                  rsp_in.out_byte  = hcs_pkg::digit_char(q_cmd.data[3:0], q_cmd.upper);
                  rsp_in.final_res = q_cmd.last;
                  count_in         = q_cmd.last ? '0 : count_inc;
                  phase_in         = 1'b0;
                  q_pop            = 1'b1;
               end
            end
            hcs_pkg::OP_BYTE: begin
               rsp_in.out_byte   = q_cmd.data;
               rsp_in.has_byte   = 1'b1;
               rsp_in.final_res  = q_cmd.last;
               rsp_in.byte_count = 16'(count_inc);
               count_in          = q_cmd.last ? '0 : count_inc;
               q_pop             = 1'b1;
            end
            default: begin
               rsp_in.out_byte   = 8'h00;
               rsp_in.has_byte   = 1'b0;
               rsp_in.final_res  = q_cmd.last;
               rsp_in.byte_count = 16'(count_ff);
               count_in          = q_cmd.last ? '0 : count_ff;
               q_pop             = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
      end
   end

endmodule

// File: rtl/hex_codec_stream.sv
// Top level of the hex codec stream: front end, command queue, back end.
// Depends on hcs_pkg, hcs_front, hcs_queue and hcs_back.
//
// Hex encoder/decoder on a byte stream. The mode register selects lower or
// upper case encode, strict decode or whitespace-skipping decode; write it
// only between runs. The front end takes one input beat per cycle while the
// four-entry command queue has room. The back end drives one result beat per
// cycle from a single output register while that register is empty or
// popped; an encode item yields one result beat per hex digit, a decode
// item at most one, and one that completes no byte and does not end a run
// none. The final result of a run carries the sticky status and the output
// count, which saturates at 2**COUNT_BITS-1 and is shown in its low 16 bits.
module hex_codec_stream #(
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data,
   input  logic              push,
   output logic              full,
   input  hcs_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output hcs_pkg::rsp_type  rsp_data
);

   logic             q_push;
   logic             q_full;
   hcs_pkg::cmd_type wr_cmd;
   logic             q_pop;
   logic             q_empty;
   hcs_pkg::cmd_type rd_cmd;

   assign full = q_full;

   hcs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .req_data    (req_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (wr_cmd)
   );

   hcs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_cmd  (wr_cmd),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_cmd  (rd_cmd),
      .q_empty (q_empty)
   );

   hcs_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_cmd    (rd_cmd),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
